// ----- src/fpalu_pkg.sv -----
// Package for the Q24.8 fixed-point ALU: operation codes, payload structs, widths.
// No dependencies.
package fpalu_pkg;

  localparam int unsigned WORD_WIDTH    = 32;
  localparam int unsigned FRACTION_BITS = 8;
  // dividend is |a| scaled up by the fraction bits; one quotient bit per stage
  localparam int unsigned DIV_WIDTH     = WORD_WIDTH + FRACTION_BITS;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,  OP_SUB  = 4'd1,  OP_MUL = 4'd2,  OP_DIV = 4'd3,
    OP_EQ   = 4'd4,  OP_NE   = 4'd5,  OP_GT  = 4'd6,  OP_LT  = 4'd7,
    OP_GE   = 4'd8,  OP_LE   = 4'd9,  OP_MIN = 4'd10, OP_MAX = 4'd11,
    OP_INC  = 4'd12, OP_DEC  = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
  } op_e;

  typedef struct packed {
    op_e                           operation;
    logic signed [WORD_WIDTH-1:0]  operand_a;
    logic signed [WORD_WIDTH-1:0]  operand_b;
  } alu_in_t;

  typedef struct packed {
    logic signed [WORD_WIDTH-1:0]  result_value;
    logic                          compare_true;
    logic                          divide_by_zero;
  } alu_out_t;

endpackage

// ----- src/fixed_point_alu.sv -----
// Q24.8 fixed-point ALU, top level: input register, execute stage, bit-per-stage
// divider pipeline and output register. Depends on fpalu_pkg.

// Accepts one operation per cycle unless the output stalls, and delivers one result
// per operation, in order. Every operation uses the same Q24.8 path: the divider
// retires one quotient bit per stage and all operations travel down the same
// pipeline. A stall on the output freezes the whole pipeline, and the stall goes
// back to the input in the same cycle. Divide by zero returns zero with
// divide_by_zero set; comparisons return zero with compare_true holding the outcome.
module fixed_point_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  fpalu_pkg::alu_in_t  in_i,
  output logic              valid_o,
  input  logic              stall_i,
  output fpalu_pkg::alu_out_t out_o
);
  import fpalu_pkg::*;

  localparam int unsigned NS = DIV_WIDTH;

  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  // input register
  logic    in_vld_q;
  alu_in_t in_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else if (en) in_vld_q <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) in_q <= in_i;
  end

  // execute stage
  logic signed [WORD_WIDTH-1:0]   a, b, res_d;
  logic                           cmp_d, lt, eq;
  logic [WORD_WIDTH-1:0]          ua, ub;
  logic signed [2*WORD_WIDTH-1:0] prod_d;
  assign a  = in_q.operand_a;
  assign b  = in_q.operand_b;
  assign lt = a < b;
  assign eq = a == b;
  assign ua = a[WORD_WIDTH-1] ? WORD_WIDTH'(-a) : WORD_WIDTH'(a);
  assign ub = b[WORD_WIDTH-1] ? WORD_WIDTH'(-b) : WORD_WIDTH'(b);
  assign prod_d = a * b;

  always_comb begin
    res_d = '0;
    cmp_d = 1'b0;
    unique case (in_q.operation)
      OP_ADD:      res_d = a + b;
      OP_SUB:      res_d = a - b;
      OP_MUL:      res_d = '0;
      OP_DIV:      res_d = '0;
      OP_EQ:       cmp_d = eq;
      OP_NE:       cmp_d = !eq;
      OP_GT:       cmp_d = !lt && !eq;
      OP_LT:       cmp_d = lt;
      OP_GE:       cmp_d = !lt;
      OP_LE:       cmp_d = lt || eq;
      OP_MIN:      res_d = lt ? a : b;
      OP_MAX:      res_d = (!lt && !eq) ? a : b;
      OP_INC:      res_d = a + WORD_WIDTH'(1);
      OP_DEC:      res_d = a - WORD_WIDTH'(1);
      OP_FROM_INT: res_d = a <<< FRACTION_BITS;
      OP_TO_INT:   res_d = a >>> FRACTION_BITS;
      default:     res_d = '0;
    endcase
  end

  // per-stage pipeline state, index 0 is the execute register
  logic [NS:0]                    vld_q;
  logic [WORD_WIDTH-1:0]          res_q [NS+1];
  logic [NS:0]                    cmp_q, div_q, neg_q, dz_q;
  logic [WORD_WIDTH-1:0]          rem_q [NS+1];
  logic [DIV_WIDTH-1:0]           num_q [NS+1];
  logic [WORD_WIDTH-1:0]          den_q [NS+1];
  logic                           mul_q;
  logic signed [2*WORD_WIDTH-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else if (en) vld_q[0] <= in_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q[0] <= res_d;
      cmp_q[0] <= cmp_d;
      mul_q    <= in_q.operation == OP_MUL;
      prod_q   <= prod_d;
      div_q[0] <= in_q.operation == OP_DIV;
      dz_q[0]  <= (in_q.operation == OP_DIV) && (b == '0);
      neg_q[0] <= a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
      rem_q[0] <= '0;
      num_q[0] <= {ua, {FRACTION_BITS{1'b0}}};
      den_q[0] <= ub;
    end
  end

  // restoring divider, one quotient bit per stage; quotient shifts into num
  for (genvar k = 0; k < NS; k++) begin : g_div
    logic [WORD_WIDTH:0]   trial;
    logic                  ge;
    logic [WORD_WIDTH:0]   diff;
    logic [WORD_WIDTH-1:0] res_in;
    assign trial  = {rem_q[k], num_q[k][DIV_WIDTH-1]};
    assign ge     = trial >= {1'b0, den_q[k]};
    assign diff   = trial - {1'b0, den_q[k]};
    // first divider stage also finishes the multiply: floor shift then wrap
    if (k == 0) begin : g_mul
      assign res_in = mul_q ? prod_q[FRACTION_BITS +: WORD_WIDTH] : res_q[k];
    end else begin : g_pass
      assign res_in = res_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[k+1] <= 1'b0;
      else if (en) vld_q[k+1] <= vld_q[k];
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        res_q[k+1] <= res_in;
        cmp_q[k+1] <= cmp_q[k];
        div_q[k+1] <= div_q[k];
        dz_q[k+1]  <= dz_q[k];
        neg_q[k+1] <= neg_q[k];
        den_q[k+1] <= den_q[k];
        rem_q[k+1] <= ge ? diff[WORD_WIDTH-1:0] : trial[WORD_WIDTH-1:0];
        num_q[k+1] <= {num_q[k][DIV_WIDTH-2:0], ge};
      end
    end
  end

  // output register
  logic [WORD_WIDTH-1:0] quo;
  alu_out_t              out_d;
  assign quo = num_q[NS][WORD_WIDTH-1:0];
  always_comb begin
    out_d.compare_true   = cmp_q[NS];
    out_d.divide_by_zero = dz_q[NS];
    if (!div_q[NS])    out_d.result_value = res_q[NS];
    else if (dz_q[NS]) out_d.result_value = '0;
    else if (neg_q[NS]) out_d.result_value = -quo;
    else               out_d.result_value = quo;
  end

  logic     out_vld_q;
  alu_out_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= vld_q[NS];
  end
  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign valid_o = out_vld_q;
  assign out_o   = out_q;

endmodule

// ----- src/fpalu_checker.sv -----
// Port-level checks for fixed_point_alu, bound to the top level below.
// Depends on fpalu_pkg.
module fpalu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                valid_i,
  input logic                stall_o,
  input fpalu_pkg::alu_in_t  in_i,
  input logic                valid_o,
  input logic                stall_i,
  input fpalu_pkg::alu_out_t out_o
);
  import fpalu_pkg::*;

  // a stalled result is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(out_o))
    else $error("stalled result changed");

  // back-pressure only comes from a stalled output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o && stall_i)
    else $error("input stalled without output stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (out_o.compare_true || out_o.divide_by_zero) |-> out_o.result_value == '0)
    else $error("flagged result not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(out_o.compare_true && out_o.divide_by_zero))
    else $error("compare and divide flags both set");

endmodule

bind fixed_point_alu fpalu_checker u_fpalu_checker (.*);

// ----- verif/fixed_point_alu_tb.sv -----
// Testbench for fixed_point_alu: a directed table followed by random operations,
// every result checked in order against a behavioural Q24.8 predictor.
// Depends on fpalu_pkg and the fixed_point_alu RTL.
`timescale 1ns / 1ps

module fixed_point_alu_tb;
  import fpalu_pkg::*;

  localparam int unsigned LATENCY     = DIV_WIDTH + 3;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned N_RANDOM    = 1530;
  localparam int unsigned LONG_HOLD   = 150;

  typedef struct {
    alu_in_t  op_item;
    bit       has_result;
    alu_out_t result;
  } directed_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     valid_i;
  logic     stall_o;
  alu_in_t  in_i;
  logic     valid_o;
  logic     stall_i;
  alu_out_t out_o;

  alu_out_t    expected_results[$];
  int unsigned error_count;
  int unsigned cycle_count;
  bit          stimulus_done;
  bit          hold_release;

  fixed_point_alu dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .in_i    (in_i),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .out_o   (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // arithmetic shift right by the fraction bits, i.e. floor division
  function automatic longint floor_scale_down(longint p);
    return p >>> FRACTION_BITS;
  endfunction

  function automatic alu_out_t alu_compute(alu_in_t item);
    alu_out_t r;
    longint a;
    longint b;
    longint w;
    a = longint'(item.operand_a);
    b = longint'(item.operand_b);
    r = '0;
    w = 0;
    case (item.operation)
      OP_ADD:      w = a + b;
      OP_SUB:      w = a - b;
      OP_MUL:      w = floor_scale_down(a * b);
      OP_DIV: begin
        if (b == 0) r.divide_by_zero = 1'b1;
        else w = (a * (longint'(1) << FRACTION_BITS)) / b;
      end
      OP_EQ:       r.compare_true = (a == b);
      OP_NE:       r.compare_true = (a != b);
      OP_GT:       r.compare_true = (a > b);
      OP_LT:       r.compare_true = (a < b);
      OP_GE:       r.compare_true = (a >= b);
      OP_LE:       r.compare_true = (a <= b);
      OP_MIN:      w = (a < b) ? a : b;
      OP_MAX:      w = (a > b) ? a : b;
      OP_INC:      w = a + 1;
      OP_DEC:      w = a - 1;
      OP_FROM_INT: w = a << FRACTION_BITS;
      default:     w = floor_scale_down(a);
    endcase
    r.result_value = w[WORD_WIDTH-1:0];
    return r;
  endfunction

  function automatic logic signed [WORD_WIDTH-1:0] random_operand();
    case ($urandom_range(0, 7))
      0: return {1'b1, {(WORD_WIDTH-1){1'b0}}};
      1: return {1'b0, {(WORD_WIDTH-1){1'b1}}};
      2: return '0;
      3: return $signed(32'($urandom_range(0, 1023)) - 32'sd512);
      4: return $signed(32'($urandom_range(0, 1 << 20)) - 32'sd524288);
      default: return $signed($urandom());
    endcase
  endfunction

  // called at a falling edge; valid stays high into the next item when there is no gap
  task automatic send_item(alu_in_t item);
    int unsigned gap;
    gap = $urandom_range(0, 18);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_i    <= item;
    valid_i <= 1'b1;
    expected_results.push_back(alu_compute(item));
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // directed table: extremes, every operation, divide by zero
  initial begin
    directed_row_t table_rows[$];
    directed_row_t row;
    alu_in_t item;
    op_e op;
    error_count   = 0;
    stimulus_done = 1'b0;
    hold_release  = 1'b0;
    rst_ni  = 1'b0;
    valid_i = 1'b0;
    in_i    = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    row.op_item = '{OP_DIV, 32'sd256, 32'sd0};
    row.has_result = 1'b1; row.result = '{32'sd0, 1'b0, 1'b1};
    table_rows.push_back(row);
    row.op_item = '{OP_DIV, 32'sh80000000, 32'sd0};
    table_rows.push_back(row);
    row.op_item = '{OP_ADD, 32'sh7fffffff, 32'sd1};
    row.result = '{32'sh80000000, 1'b0, 1'b0};
    table_rows.push_back(row);
    row.op_item = '{OP_INC, 32'sh7fffffff, 32'sh0};
    table_rows.push_back(row);
    row.op_item = '{OP_DEC, 32'sh80000000, 32'sh0};
    row.result = '{32'sh7fffffff, 1'b0, 1'b0};
    table_rows.push_back(row);
    row.op_item = '{OP_EQ, 32'sh80000000, 32'sh80000000};
    row.result = '{32'sd0, 1'b1, 1'b0};
    table_rows.push_back(row);
    row.op_item = '{OP_TO_INT, -32'sd1, 32'sh0};
    row.result = '{-32'sd1, 1'b0, 1'b0};
    table_rows.push_back(row);
    row.has_result = 1'b0;
    for (int i = 0; i < 16; i++) begin
      op = op_e'(i);
      row.op_item = '{op, (i % 2) ? 32'sh80000000 : 32'sh7fffffff,
                      (i % 3) ? -32'sd384 : 32'sh7fffffff};
      table_rows.push_back(row);
    end
    row.op_item = '{OP_DIV, 32'sh80000000, -32'sd1};
    table_rows.push_back(row);
    row.op_item = '{OP_MUL, 32'sh80000000, 32'sh80000000};
    table_rows.push_back(row);

    foreach (table_rows[i]) begin
      if (table_rows[i].has_result &&
          alu_compute(table_rows[i].op_item) != table_rows[i].result) begin
        $display("%0t table row %0d disagrees with predictor: expected %h actual %h",
                 $time, i, table_rows[i].result, alu_compute(table_rows[i].op_item));
        error_count++;
      end
      send_item(table_rows[i].op_item);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      item.operation = op_e'($urandom_range(0, 15));
      item.operand_a = random_operand();
      item.operand_b = ($urandom_range(0, 9) == 0) ? item.operand_a : random_operand();
      if (item.operation == OP_DIV && $urandom_range(0, 7) == 0) item.operand_b = '0;
      if (n == 400) hold_release = 1'b1;
      send_item(item);
    end
    valid_i <= 1'b0;
    stimulus_done = 1'b1;
  end

  // receiver: random stall per item, one long hold-off partway through
  initial begin
    int unsigned wait_cycles;
    stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_release) begin
        hold_release = 1'b0;
        stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
        stall_i <= 1'b0;
      end else if (valid_o && !stall_i) begin
        wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
        if (wait_cycles != 0) begin
          stall_i <= 1'b1;
          repeat (wait_cycles) @(negedge clk_i);
          stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    alu_out_t exp_r;
    if (rst_ni && valid_o && !stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected transfer: expected none actual %h", $time, out_o);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_o.result_value !== exp_r.result_value) begin
          $display("%0t result_value: expected %h actual %h",
                   $time, exp_r.result_value, out_o.result_value);
          error_count++;
        end
        if (out_o.compare_true !== exp_r.compare_true) begin
          $display("%0t compare_true: expected %b actual %b",
                   $time, exp_r.compare_true, out_o.compare_true);
          error_count++;
        end
        if (out_o.divide_by_zero !== exp_r.divide_by_zero) begin
          $display("%0t divide_by_zero: expected %b actual %b",
                   $time, exp_r.divide_by_zero, out_o.divide_by_zero);
          error_count++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    fork
      begin
        wait (stimulus_done && expected_results.size() == 0);
        repeat (LATENCY + 10) @(posedge clk_i);
      end
      begin
        while (cycle_count < CYCLE_LIMIT) begin
          @(posedge clk_i);
          cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        error_count++;
      end
    join_any
    if (error_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
